// ===== hdl/display_symbol_encoder_assert.svh =====
// Assertion macros for the display symbol encoder checker.
// Used by dse_checker.sv; needs clk_i and rst_ni in the including scope.
`ifndef DISPLAY_SYMBOL_ENCODER_ASSERT_SVH
`define DISPLAY_SYMBOL_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define DSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("display symbol encoder assertion failed");

// Next-cycle implication, disabled while in reset
`define DSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("display symbol encoder assertion failed");

`endif

// ===== hdl/dse_pkg.sv =====
// Shared types, constants and code tables of the display symbol encoder.
// No dependencies; used by dse_front, dse_back, the top level, the checker and the testbench.
`default_nettype none

package dse_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ConvSteps  = 32;
  localparam int unsigned NumDigits  = 10;

  localparam logic [7:0] SymSpace = 8'hCB;
  localparam logic [7:0] SymMinus = 8'hE3;

  typedef enum logic {
    OpChar   = 1'b0,
    OpNumber = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkConv,
    BkLead,
    BkSign,
    BkEmit
  } back_state_e;

  // Classified request as it sits in the queue
  typedef struct packed {
    opcode_e     op;
    logic [7:0]  code;
    logic        neg;
    logic [31:0] mag;
  } entry_t;

  function automatic logic [7:0] digit_code(logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0: c = 8'hED;
      4'd1: c = 8'hD5;
      4'd2: c = 8'hEF;
      4'd3: c = 8'hD7;
      4'd4: c = 8'hF1;
      4'd5: c = 8'hD9;
      4'd6: c = 8'hF3;
      4'd7: c = 8'hDB;
      4'd8: c = 8'hF5;
      4'd9: c = 8'hDD;
      default: c = SymSpace;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] letter_code(logic [4:0] i);
    logic [7:0] c;
    case (i)
      5'd0:  c = 8'h89;
      5'd1:  c = 8'h8B;
      5'd2:  c = 8'h8D;
      5'd3:  c = 8'h8F;
      5'd4:  c = 8'h91;
      5'd5:  c = 8'h93;
      5'd6:  c = 8'h95;
      5'd7:  c = 8'h97;
      5'd8:  c = 8'h99;
      5'd9:  c = 8'h9B;
      5'd10: c = 8'h9D;
      5'd11: c = 8'h9F;
      5'd12: c = 8'hA3;
      5'd13: c = 8'hA5;
      5'd14: c = 8'hA7;
      5'd15: c = 8'hA9;
      5'd16: c = 8'hAB;
      5'd17: c = 8'hAD;
      5'd18: c = 8'hAF;
      5'd19: c = 8'hB1;
      5'd20: c = 8'hB3;
      5'd21: c = 8'hB5;
      5'd22: c = 8'hB7;
      5'd23: c = 8'hB9;
      5'd24: c = 8'hBB;
      5'd25: c = 8'hBD;
      default: c = SymSpace;
    endcase
    return c;
  endfunction

  // ASCII byte to display code; unlisted bytes give the space code
  function automatic logic [7:0] char_code(logic [7:0] ch);
    logic [7:0] c;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      c = letter_code(5'(ch - 8'h41));
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      c = letter_code(5'(ch - 8'h61));
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      c = digit_code(4'(ch - 8'h30));
    end else begin
      case (ch)
        8'h2C: c = 8'hBF;  // comma
        8'h28: c = 8'hC5;  // open paren
        8'h2E: c = 8'hC7;  // period
        8'h2B: c = 8'hC9;  // plus
        8'h20: c = 8'hCB;  // space
        8'h3E: c = 8'hCD;  // greater than
        8'h24: c = 8'hCF;  // dollar
        8'h3A: c = 8'hD1;  // colon
        8'h2F: c = 8'hD3;  // slash
        8'h29: c = 8'hDF;  // close paren
        8'h2D: c = 8'hE3;  // minus
        8'h3D: c = 8'hE5;  // equals
        8'h3C: c = 8'hE7;  // less than
        8'h25: c = 8'hE9;  // percent
        8'h2A: c = 8'hEB;  // asterisk
        8'h0A: c = 8'hF7;  // line feed
        8'h3F: c = 8'hF9;  // question mark
        8'h21: c = 8'hFB;  // exclamation
        8'h23: c = 8'hFD;  // number sign
        8'h40: c = 8'hFF;  // at sign
        default: c = SymSpace;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dse_in_if.sv =====
// Request channel of the display symbol encoder: valid, ready, payload.
// No dependencies.
`default_nettype none

interface dse_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic        [7:0]  character;
  logic signed [31:0] number;

  modport source (output valid, output opcode, output character, output number,
                  input ready);
  modport sink   (input valid, input opcode, input character, input number,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/dse_out_if.sv =====
// Symbol channel of the display symbol encoder: valid, ready, payload.
// No dependencies.
`default_nettype none

interface dse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_code;
  logic       last_symbol;

  modport source (output valid, output symbol_code, output last_symbol, input ready);
  modport sink   (input valid, input symbol_code, input last_symbol, output ready);
endinterface

`default_nettype wire

// ===== hdl/dse_front.sv =====
// Front end: accepts requests, classifies them and queues them.
// Depends on dse_pkg and dse_in_if.
`default_nettype none

module dse_front #(
  parameter int unsigned Depth = dse_pkg::QueueDepth
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  dse_in_if.sink         in_i,
  output dse_pkg::entry_t head_o,
  output logic           head_valid_o,
  input  wire logic      pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dse_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;
  dse_pkg::entry_t entry;

  // Classify: character lookup, sign and magnitude
  always_comb begin
    entry.op   = dse_pkg::opcode_e'(in_i.opcode);
    entry.code = dse_pkg::char_code(in_i.character);
    entry.neg  = in_i.number[31];
    entry.mag  = in_i.number[31] ? (32'd0 - 32'(in_i.number)) : 32'(in_i.number);
  end

  assign in_i.ready   = (cnt_q != FullCnt);
  assign push         = in_i.valid && in_i.ready;
  assign head_valid_o = (cnt_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dse_back.sv =====
// Back end: converts queued requests to symbol codes and drives the output.
// Depends on dse_pkg and dse_out_if.
`default_nettype none

module dse_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dse_pkg::entry_t head_i,
  input  wire logic            head_valid_i,
  output logic                 pop_o,
  dse_out_if.source            out_o
);

  localparam int unsigned BcdW = 4 * dse_pkg::NumDigits;
  localparam int unsigned StepW = $clog2(dse_pkg::ConvSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(dse_pkg::ConvSteps - 1);
  localparam int unsigned IdxW = $clog2(dse_pkg::NumDigits);

  dse_pkg::back_state_e state_q, state_d;

  logic [BcdW-1:0]  bcd_q, bcd_adj;
  logic [31:0]      bin_q;
  logic [StepW-1:0] step_q;
  logic [IdxW-1:0]  idx_q, lead_idx;
  logic             neg_q;

  logic             out_valid_q;
  logic [7:0]       out_sym_q;
  logic             out_last_q;

  logic             slot_free;
  logic             emit, emit_last, load_conv, step_conv, load_idx, dec_idx;
  logic [7:0]       emit_sym;

  assign slot_free   = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.symbol_code = out_sym_q;
  assign out_o.last_symbol = out_last_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dse_pkg::BkIdle: begin
        if (head_valid_i && head_i.op == dse_pkg::OpNumber) begin
          state_d = dse_pkg::BkConv;
        end
      end
      dse_pkg::BkConv: begin
        if (step_q == LastStep) begin
          state_d = dse_pkg::BkLead;
        end
      end
      dse_pkg::BkLead: begin
        state_d = neg_q ? dse_pkg::BkSign : dse_pkg::BkEmit;
      end
      dse_pkg::BkSign: begin
        if (slot_free) begin
          state_d = dse_pkg::BkEmit;
        end
      end
      dse_pkg::BkEmit: begin
        if (slot_free && idx_q == '0) begin
          state_d = dse_pkg::BkIdle;
        end
      end
      default: state_d = dse_pkg::BkIdle;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_sym  = head_i.code;
    emit_last = 1'b1;
    load_conv = 1'b0;
    step_conv = 1'b0;
    load_idx  = 1'b0;
    dec_idx   = 1'b0;
    case (state_q)
      dse_pkg::BkIdle: begin
        if (head_valid_i && head_i.op == dse_pkg::OpChar && slot_free) begin
          pop_o = 1'b1;
          emit  = 1'b1;
        end else if (head_valid_i && head_i.op == dse_pkg::OpNumber) begin
          pop_o     = 1'b1;
          load_conv = 1'b1;
        end
      end
      dse_pkg::BkConv: step_conv = 1'b1;
      dse_pkg::BkLead: load_idx  = 1'b1;
      dse_pkg::BkSign: begin
        emit      = slot_free;
        emit_sym  = dse_pkg::SymMinus;
        emit_last = 1'b0;
      end
      dse_pkg::BkEmit: begin
        emit      = slot_free;
        dec_idx   = slot_free;
        emit_sym  = dse_pkg::digit_code(bcd_q[{idx_q, 2'b00} +: 4]);
        emit_last = (idx_q == '0);
      end
      default: ;
    endcase
  end

  // Double-dabble adjust: add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < dse_pkg::NumDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  // Highest nonzero digit; zero gives a single digit
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < dse_pkg::NumDigits; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        lead_idx = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dse_pkg::BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_sym_q  <= emit_sym;
      out_last_q <= emit_last;
    end
    if (load_conv) begin
      bcd_q  <= '0;
      bin_q  <= head_i.mag;
      neg_q  <= head_i.neg;
      step_q <= '0;
    end else if (step_conv) begin
      bcd_q  <= {bcd_adj[BcdW-2:0], bin_q[31]};
      bin_q  <= {bin_q[30:0], 1'b0};
      step_q <= step_q + 1'b1;
    end
    if (load_idx) begin
      idx_q <= lead_idx;
    end else if (dec_idx && idx_q != '0) begin
      idx_q <= idx_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/display_symbol_encoder.sv =====
// Top level of the display symbol encoder: front queue plus back converter.
// Depends on dse_pkg, dse_in_if, dse_out_if, dse_front and dse_back.
//
// Usage:
//   in_i  takes requests: opcode 0 translates the character byte into one
//         symbol code, opcode 1 prints the signed number in decimal
//         (leading minus code if negative, digits most significant first).
//   out_o gives one or more symbol codes per request; last_symbol marks the final one.
//   A character request passes through the request queue and the output register.
//   A number request runs a 32-step binary-to-BCD shift converter, then gives one
//   symbol per cycle while the receiver takes them.
//   Throughput: one character request per cycle while the receiver takes symbols;
//   a number request holds the converter until its last symbol (up to 11) is issued.
//   The request queue (QDepth entries) keeps accepting while the converter
//   works or while a symbol waits at the output.
//   Reset empties the queue and drops any symbol in progress.
//   When the receiver stalls, the symbol holds on out_o and the back end waits
//   before issuing its next symbol; in_i.ready falls once the queue is full.
`default_nettype none

module display_symbol_encoder #(
  parameter int unsigned QDepth = dse_pkg::QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dse_in_if.sink    in_i,
  dse_out_if.source out_o
);

  dse_pkg::entry_t head;
  logic            head_valid;
  logic            pop;

  dse_front #(
    .Depth(QDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .head_o      (head),
    .head_valid_o(head_valid),
    .pop_i       (pop)
  );

  dse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .head_valid_i(head_valid),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== hdl/dse_checker.sv =====
// Port-level checker of the display symbol encoder, bound to the top level.
// Depends on display_symbol_encoder_assert.svh and dse_pkg.
`default_nettype none

`include "display_symbol_encoder_assert.svh"

module dse_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] symbol_code_i,
  input wire logic       last_symbol_i
);

  logic non_last_ok;

  // A symbol that is not last belongs to a number: minus or a digit code
  assign non_last_ok = (symbol_code_i == dse_pkg::SymMinus) ||
                       (symbol_code_i == 8'hED) || (symbol_code_i == 8'hD5) ||
                       (symbol_code_i == 8'hEF) || (symbol_code_i == 8'hD7) ||
                       (symbol_code_i == 8'hF1) || (symbol_code_i == 8'hD9) ||
                       (symbol_code_i == 8'hF3) || (symbol_code_i == 8'hDB) ||
                       (symbol_code_i == 8'hF5) || (symbol_code_i == 8'hDD);

  // Stalled symbol stays offered
  `DSE_ASSERT_NEXT(a_hold_valid, out_valid_i && !out_ready_i, out_valid_i)

  // Stalled symbol keeps its payload
  `DSE_ASSERT_NEXT(a_hold_data, out_valid_i && !out_ready_i, $stable(symbol_code_i) && $stable(last_symbol_i))

  // Only number requests give several symbols
  `DSE_ASSERT_NOW(a_multi_is_number, out_valid_i && !last_symbol_i, non_last_ok)

endmodule

bind display_symbol_encoder dse_checker u_dse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .symbol_code_i(out_o.symbol_code),
  .last_symbol_i(out_o.last_symbol)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for display_symbol_encoder: drives character and number requests,
// predicts every symbol code and last flag and compares them in order.
// Depends on dse_pkg, dse_in_if, dse_out_if and the display_symbol_encoder RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumRandom  = 430;
  localparam int unsigned DrainWait  = 60;

  // One expected symbol on the output channel
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } symbol_t;

  // Expected-symbol store plus the encoder predictor
  class symbol_scoreboard;
    symbol_t expected_q[$];
    int errors;
    int checked;
    int char_reqs;
    int num_reqs;
    int full_runs;

    function logic [7:0] digit_sym(int d);
      logic [7:0] s;
      case (d)
        0: s = 8'hED;
        1: s = 8'hD5;
        2: s = 8'hEF;
        3: s = 8'hD7;
        4: s = 8'hF1;
        5: s = 8'hD9;
        6: s = 8'hF3;
        7: s = 8'hDB;
        8: s = 8'hF5;
        default: s = 8'hDD;
      endcase
      return s;
    endfunction

    function logic [7:0] char_sym(logic [7:0] ch);
      logic [7:0] up;
      int idx;
      up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      if (up >= "A" && up <= "Z") begin
        // letter codes step by two, with a hole at 0xA1 after L
        idx = int'(up - "A");
        return (idx < 12) ? 8'(8'h89 + 2 * idx) : 8'(8'hA3 + 2 * (idx - 12));
      end
      if (ch >= "0" && ch <= "9") return digit_sym(int'(ch - "0"));
      case (ch)
        ",":  return 8'hBF;
        "(":  return 8'hC5;
        ".":  return 8'hC7;
        "+":  return 8'hC9;
        ">":  return 8'hCD;
        "$":  return 8'hCF;
        ":":  return 8'hD1;
        "/":  return 8'hD3;
        ")":  return 8'hDF;
        "-":  return 8'hE3;
        "=":  return 8'hE5;
        "<":  return 8'hE7;
        "%":  return 8'hE9;
        "*":  return 8'hEB;
        "\n": return 8'hF7;
        "?":  return 8'hF9;
        "!":  return 8'hFB;
        "#":  return 8'hFD;
        "@":  return 8'hFF;
        default: return dse_pkg::SymSpace;
      endcase
    endfunction

    // Queue the symbols that one accepted request must produce
    function void note_request(dse_pkg::opcode_e op, logic [7:0] ch, logic [31:0] num);
      logic [7:0] syms[$];
      logic [31:0] mag;
      symbol_t s;
      if (op == dse_pkg::OpChar) begin
        char_reqs++;
        syms.push_back(char_sym(ch));
      end else begin
        num_reqs++;
        // most negative value: two's complement negate gives the right unsigned magnitude
        mag = num[31] ? -num : num;
        do begin
          syms.push_front(digit_sym(int'(mag % 10)));
          mag = mag / 10;
        end while (mag != 0);
        if (num[31]) syms.push_front(dse_pkg::SymMinus);
        if (syms.size() == 11) full_runs++;
      end
      foreach (syms[k]) begin
        s.code = syms[k];
        s.last = (k == syms.size() - 1);
        expected_q.push_back(s);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] symbol error: %s", $time, msg);
    endtask

    task check_symbol(logic [7:0] code, logic last);
      symbol_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected symbol %02h last %0b", code, last));
        return;
      end
      want = expected_q.pop_front();
      if (code !== want.code)
        report_mismatch($sformatf("code %02h, want %02h", code, want.code));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b (code %02h)", last, want.last, want.code));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  int rx_cycle;
  int stall_left;
  symbol_scoreboard sb;

  dse_in_if  in_if ();
  dse_out_if out_if ();

  display_symbol_encoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver ready: rotates through always-ready, random, periodic and long-stall phases
  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle++;
      case ((rx_cycle / 150) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ((rx_cycle % 7) < 4);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
          end else begin
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 8);
            out_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_symbol(out_if.symbol_code, out_if.last_symbol);
  end

  // Drive one request from a falling edge; returns at the falling edge after acceptance
  task automatic send_request(dse_pkg::opcode_e op, logic [7:0] ch, logic [31:0] num);
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.character <= ch;
    in_if.number    <= num;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(op, ch, num);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_character();
    string punct = "(),.+ >$:/-=<%*\n?!#@";
    logic [7:0] ch;
    case ($urandom_range(0, 3))
      0: ch = 8'("A" + $urandom_range(0, 25)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      1: ch = 8'("0" + $urandom_range(0, 9));
      2: ch = punct[$urandom_range(0, punct.len() - 1)];
      default: ch = 8'($urandom_range(0, 255));
    endcase
    return ch;
  endfunction

  function automatic logic [31:0] pick_number();
    longint unsigned span;
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: begin
        // power of ten picked uniformly, then a value below that power of ten
        span = 1;
        repeat ($urandom_range(1, 10)) span *= 10;
        v = 32'({32'b0, $urandom} % span);
      end
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end
      default: v = $urandom_range(0, 9);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  initial begin
    int burst_left;
    int gap;
    sb = new();
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = dse_pkg::OpChar;
    in_if.character  = 8'h00;
    in_if.number     = 32'sd0;
    out_if.ready     = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: table corners, case folding, unlisted bytes, number extremes
    send_request(dse_pkg::OpChar, "A", $urandom);
    send_request(dse_pkg::OpChar, "z", $urandom);
    send_request(dse_pkg::OpChar, "l", 32'h0);
    send_request(dse_pkg::OpChar, "M", 32'hFFFF_FFFF);
    send_request(dse_pkg::OpChar, "0", $urandom);
    send_request(dse_pkg::OpChar, "9", $urandom);
    send_request(dse_pkg::OpChar, "#", $urandom);
    send_request(dse_pkg::OpChar, "@", $urandom);
    send_request(dse_pkg::OpChar, "\n", $urandom);
    send_request(dse_pkg::OpChar, " ", $urandom);
    send_request(dse_pkg::OpChar, 8'h00, $urandom);
    send_request(dse_pkg::OpChar, 8'h7F, $urandom);
    send_request(dse_pkg::OpChar, 8'h80, $urandom);
    send_request(dse_pkg::OpChar, 8'hFF, $urandom);
    send_request(dse_pkg::OpChar, "{", $urandom);
    send_request(dse_pkg::OpNumber, 8'hFF, 32'd0);
    send_request(dse_pkg::OpNumber, 8'h41, 32'd1);
    send_request(dse_pkg::OpNumber, 8'h00, 32'hFFFF_FFFF);
    send_request(dse_pkg::OpNumber, 8'($urandom), 32'h7FFF_FFFF);
    send_request(dse_pkg::OpNumber, 8'($urandom), 32'h8000_0000);
    send_request(dse_pkg::OpNumber, 8'($urandom), 32'h8000_0001);
    send_request(dse_pkg::OpNumber, 8'($urandom), -32'd10);
    send_request(dse_pkg::OpNumber, 8'($urandom), 32'd1_000_000_000);
    send_request(dse_pkg::OpNumber, 8'($urandom), 32'd9);

    // Random requests in bursts; one stretch runs without gaps
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 99) < 45)
        send_request(dse_pkg::OpChar, pick_character(), $urandom);
      else
        send_request(dse_pkg::OpNumber, 8'($urandom), pick_number());
      if (i >= 150 && i < 230) continue;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 15);
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_if.valid <= 1'b0;

    // Drain, then watch for stray symbols
    while (sb.pending() > 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Covered %0d character and %0d number requests, %0d symbols compared.",
             sb.char_reqs, sb.num_reqs, sb.checked);
    $display("%0d number requests produced the full eleven-symbol run.", sb.full_runs);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dse_pkg.sv
hdl/dse_in_if.sv
hdl/dse_out_if.sv
hdl/dse_front.sv
hdl/dse_back.sv
hdl/display_symbol_encoder.sv
hdl/dse_checker.sv
bench/tb.sv
